### rtl/djnm_pkg.sv
package djnm_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_FIND  = 2'd2,
    CMD_MERGE = 2'd3
  } cmd_t;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_ZERO_E    = 2'd1;
  localparam logic [1:0] ST_ZERO_PMAG = 2'd2;

  // One queued command from the front end to the execution engine.
  typedef struct packed {
    cmd_t        cmd;
    logic [9:0]  idx_i;
    logic [9:0]  idx_j;
    logic        in_range;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic [31:0] en;
  } djnm_cmd_t;

  function automatic logic [31:0] sat32(input logic signed [35:0] v);
    logic [31:0] r;
    if (v > 36'sh0_7FFF_FFFF) r = 32'h7FFF_FFFF;
    else if (v < -36'sh0_8000_0000) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

### rtl/djnm_front.sv
// Front end: checks index range and queues commands in a two-entry FIFO.
module djnm_front #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [1:0]          in_command,
  input  logic [5:0]          in_entry_index,
  input  logic [5:0]          in_other_index,
  input  logic [31:0]         in_mom_x,
  input  logic [31:0]         in_mom_y,
  input  logic [31:0]         in_mom_z,
  input  logic [31:0]         in_energy,
  output logic                busy,
  output logic                q_valid,
  output djnm_pkg::djnm_cmd_t q_data,
  input  logic                q_pop
);
  djnm_pkg::djnm_cmd_t fifo_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  djnm_pkg::djnm_cmd_t cw;
  logic push;
  logic ok_i, ok_j;

  assign busy    = (cnt_r == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (cnt_r != 2'd0);
  assign q_data  = fifo_r[rp_r];

  always_comb begin
    ok_i = ({5'd0, in_entry_index} < 11'(TABLE_DEPTH));
    ok_j = ({5'd0, in_other_index} < 11'(TABLE_DEPTH));
    cw.cmd   = djnm_pkg::cmd_t'(in_command);
    cw.idx_i = {4'd0, in_entry_index};
    cw.idx_j = {4'd0, in_other_index};
    cw.in_range = (djnm_pkg::cmd_t'(in_command) == djnm_pkg::CMD_MERGE) ?
                  (ok_i && ok_j) : ok_i;
    cw.px = in_mom_x;
    cw.py = in_mom_y;
    cw.pz = in_mom_z;
    cw.en = in_energy;
  end

  always_ff @(posedge clk) begin
    if (push) fifo_r[wp_r] <= cw;
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end
endmodule

### rtl/djnm_sqrt.sv
// Bit-serial integer square root of a 68-bit value, one result bit per cycle.
module djnm_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [67:0] rad,
  output logic        done,
  output logic [33:0] root
);
  logic [67:0] rem_r;
  logic [69:0] acc_r;
  logic [33:0] q_r;
  logic [5:0]  n_r;
  logic        run_r;
  logic [69:0] acc_sh;
  logic [69:0] trial;

  assign root = q_r;
  always_comb begin
    acc_sh = {acc_r[67:0], rem_r[67:66]};
    trial  = {34'd0, q_r, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
        n_r   <= 6'd0;
        rem_r <= rad;
        acc_r <= 70'd0;
        q_r   <= 34'd0;
      end else if (run_r) begin
        rem_r <= {rem_r[65:0], 2'b00};
        if (acc_sh >= trial) begin
          acc_r <= acc_sh - trial;
          q_r   <= {q_r[32:0], 1'b1};
        end else begin
          acc_r <= acc_sh;
          q_r   <= {q_r[32:0], 1'b0};
        end
        n_r <= n_r + 6'd1;
        if (n_r == 6'd33) begin
          run_r <= 1'b0;
          done  <= 1'b1;
        end
      end
    end
  end
endmodule

### rtl/djnm_div.sv
// Restoring divider: 64-bit dividend by 34-bit divisor, one quotient bit per cycle.
module djnm_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [63:0] num,
  input  logic [33:0] den,
  output logic        done,
  output logic [63:0] quo
);
  logic [63:0] q_r;
  logic [34:0] rem_r;
  logic [33:0] d_r;
  logic [6:0]  n_r;
  logic        run_r;
  logic [34:0] sh;

  assign quo = q_r;
  assign sh  = {rem_r[33:0], q_r[63]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
        q_r   <= num;
        d_r   <= den;
        rem_r <= 35'd0;
        n_r   <= 7'd0;
      end else if (run_r) begin
        if (sh >= {1'b0, d_r}) begin
          rem_r <= sh - {1'b0, d_r};
          q_r   <= {q_r[62:0], 1'b1};
        end else begin
          rem_r <= sh;
          q_r   <= {q_r[62:0], 1'b0};
        end
        n_r <= n_r + 7'd1;
        if (n_r == 7'd63) begin
          run_r <= 1'b0;
          done  <= 1'b1;
        end
      end
    end
  end
endmodule

### rtl/djnm_back.sv
// Execution engine: table memories, sequencer, shared multiplier, sqrt and divider.
module djnm_back #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                mode,
  input  logic                q_valid,
  input  djnm_pkg::djnm_cmd_t q_data,
  output logic                q_pop,
  output logic                out_strobe,
  output logic [1:0]          out_status,
  output logic                out_found,
  output logic [5:0]          out_neighbour_index,
  output logic [63:0]         out_distance
);
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  typedef enum logic [16:0] {
    S_IDLE  = 17'h00001,
    S_DISP  = 17'h00002,
    S_RDI   = 17'h00004,
    S_LATI  = 17'h00008,
    S_NORM  = 17'h00010,
    S_SQRT  = 17'h00020,
    S_UNIT  = 17'h00040,
    S_DIVW  = 17'h00080,
    S_SCAN  = 17'h00100,
    S_RDK   = 17'h00200,
    S_LATK  = 17'h00400,
    S_DIST  = 17'h00800,
    S_DMUL  = 17'h01000,
    S_RDJ   = 17'h02000,
    S_LATJ  = 17'h04000,
    S_MSUM  = 17'h08000,
    S_DONE  = 17'h10000
  } state_t;

  state_t state_r;
  djnm_pkg::djnm_cmd_t c_r;

  logic [31:0] mem_x [TABLE_DEPTH];
  logic [31:0] mem_y [TABLE_DEPTH];
  logic [31:0] mem_z [TABLE_DEPTH];
  logic [31:0] mem_e [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] valid_r;

  logic [AW-1:0] raddr_r;
  logic [31:0] rx_r, ry_r, rz_r, re_r;
  logic        we_r;
  logic [AW-1:0] waddr_r;
  logic [31:0] wx_r, wy_r, wz_r, we_e_r;

  // Working vector (entry i or summed momentum), current candidate.
  logic signed [33:0] vx_r, vy_r, vz_r;
  logic signed [31:0] ei_r, ek_r;
  logic signed [31:0] se_r;
  logic signed [31:0] kx_r, ky_r, kz_r;
  logic [67:0]  n2_r;
  logic [1:0]   comp_r;
  logic [33:0]  mag_r;
  logic         pass_r;   // 0: entry i / merge, 1: candidate
  logic signed [31:0] ui_r [3];
  logic signed [31:0] uk_r [3];
  logic [63:0]  s_r;
  logic [63:0]  m2_r;
  logic [127:0] pacc_r;
  logic [63:0]  prod_r;
  logic [AW:0]  k_r;
  logic         found_r;
  logic [AW-1:0] best_r;
  logic [63:0]  bestd_r;
  logic [1:0]   status_r;
  logic [2:0]   mstep_r;

  logic         sq_go, sq_done, dv_go, dv_done;
  logic [33:0]  sq_root;
  logic [63:0]  dv_num, dv_quo;
  logic [33:0]  dv_den;

  djnm_sqrt u_sqrt (.clk, .rst_n, .go(sq_go), .rad(n2_r), .done(sq_done), .root(sq_root));
  djnm_div  u_div  (.clk, .rst_n, .go(dv_go), .num(dv_num), .den(dv_den),
                    .done(dv_done), .quo(dv_quo));

  // Shared 34x34 magnitude multiplier.
  logic [33:0] ma, mb;
  logic [67:0] mp;
  assign mp = ma * mb;

  // Partial product of m^2 * s placed at its limb weight.
  logic [127:0] pp_sh;
  always_comb begin
    case (mstep_r[1:0])
      2'd0:    pp_sh = {64'd0, mp[63:0]};
      2'd3:    pp_sh = {mp[63:0], 64'd0};
      default: pp_sh = {32'd0, mp[63:0], 32'd0};
    endcase
  end

  function automatic logic [33:0] abs34(input logic signed [33:0] v);
    return v[33] ? 34'(-v) : 34'(v);
  endfunction

  logic signed [33:0] cur_c;
  logic signed [31:0] cur_k;
  always_comb begin
    case (comp_r)
      2'd0:    cur_c = vx_r;
      2'd1:    cur_c = vy_r;
      default: cur_c = vz_r;
    endcase
    case (comp_r)
      2'd0:    cur_k = kx_r;
      2'd1:    cur_k = ky_r;
      default: cur_k = kz_r;
    endcase
  end

  logic signed [33:0] sel_c;
  assign sel_c = pass_r ? 34'(cur_k) : cur_c;

  logic signed [32:0] diff_c;
  assign diff_c = 33'(ui_r[comp_r]) - 33'(uk_r[comp_r]);

  logic signed [31:0] emin;
  assign emin = (ei_r < ek_r) ? ei_r : ek_r;

  always_comb begin
    ma = abs34(sel_c);
    mb = abs34(sel_c);
    dv_num = 64'(ma) << 30;
    if (state_r == S_DIST && comp_r != 2'd3) begin
      ma = 34'(abs34(34'(diff_c)));
      mb = ma;
    end else if (state_r == S_DIST) begin
      ma = 34'(abs34(34'(emin)));
      mb = ma;
    end else if (state_r == S_DMUL) begin
      ma = {2'b00, mstep_r[1] ? m2_r[63:32] : m2_r[31:0]};
      mb = {2'b00, mstep_r[0] ? s_r[63:32] : s_r[31:0]};
    end else if (state_r == S_UNIT && c_r.cmd == djnm_pkg::CMD_MERGE) begin
      ma = abs34(cur_c);
      mb = abs34(34'(se_r));
      dv_num = 64'(mp);
    end
    dv_den = mag_r;
  end

  // m^2 * s is built from four 32x32 limb products accumulated in turn on the
  // shared multiplier; the distance is the product shifted down by 76.
  logic [63:0] dnew;
  assign dnew = {12'd0, pacc_r[127:76]};

  logic neg_c;
  assign neg_c = pass_r ? cur_k[31] : cur_c[33];
  logic neg_m;
  assign neg_m = cur_c[33] ^ se_r[31];

  // Rescaled merge component, saturated to 32 bits.
  logic [31:0] rs_val;
  always_comb begin
    if (|dv_quo[63:35]) rs_val = neg_m ? 32'h8000_0000 : 32'h7FFF_FFFF;
    else rs_val = djnm_pkg::sat32(neg_m ? -36'(dv_quo[34:0]) : 36'(dv_quo[34:0]));
  end

  assign sq_go = (state_r == S_NORM) && (comp_r == 2'd3);

  always_comb begin
    dv_go = 1'b0;
    if (state_r == S_UNIT) dv_go = 1'b1;
  end

  logic [AW-1:0] ci, cj, kk;
  assign ci = c_r.idx_i[AW-1:0];
  assign cj = c_r.idx_j[AW-1:0];
  assign kk = k_r[AW-1:0];

  assign q_pop = (state_r == S_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    rx_r <= mem_x[raddr_r];
    ry_r <= mem_y[raddr_r];
    rz_r <= mem_z[raddr_r];
    re_r <= mem_e[raddr_r];
    if (we_r) begin
      mem_x[waddr_r] <= wx_r;
      mem_y[waddr_r] <= wy_r;
      mem_z[waddr_r] <= wz_r;
      mem_e[waddr_r] <= we_e_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      valid_r    <= '0;
      we_r       <= 1'b0;
      out_strobe <= 1'b0;
    end else begin
      we_r       <= 1'b0;
      out_strobe <= 1'b0;
      unique case (state_r)
        S_IDLE: if (q_valid) begin
          c_r      <= q_data;
          found_r  <= 1'b0;
          status_r <= djnm_pkg::ST_OK;
          best_r   <= '0;
          bestd_r  <= '0;
          pass_r   <= 1'b0;
          state_r  <= S_DISP;
        end
        S_DISP: begin
          state_r <= S_DONE;
          raddr_r <= ci;
          if (c_r.in_range) begin
            unique case (c_r.cmd)
              djnm_pkg::CMD_LOAD: begin
                if (c_r.en == 32'd0) status_r <= djnm_pkg::ST_ZERO_E;
                else begin
                  we_r <= 1'b1; waddr_r <= ci;
                  wx_r <= c_r.px; wy_r <= c_r.py; wz_r <= c_r.pz; we_e_r <= c_r.en;
                  valid_r[ci] <= 1'b1;
                end
              end
              djnm_pkg::CMD_CLEAR: valid_r[ci] <= 1'b0;
              djnm_pkg::CMD_FIND:  if (valid_r[ci]) state_r <= S_RDI;
              djnm_pkg::CMD_MERGE: if (valid_r[ci] && valid_r[cj]) state_r <= S_RDI;
              default: ;
            endcase
          end
        end
        S_RDI: begin
          raddr_r <= cj;
          state_r <= S_LATI;
        end
        S_LATI: begin
          vx_r <= 34'(signed'(rx_r)); vy_r <= 34'(signed'(ry_r));
          vz_r <= 34'(signed'(rz_r)); ei_r <= re_r;
          if (c_r.cmd == djnm_pkg::CMD_MERGE) state_r <= S_LATJ;
          else begin
            n2_r <= '0; comp_r <= 2'd0; state_r <= S_NORM;
          end
        end
        S_LATJ: begin
          if (mode) begin
            we_r <= 1'b1; waddr_r <= ci;
            wx_r <= djnm_pkg::sat32(36'(vx_r) + 36'(signed'(rx_r)));
            wy_r <= djnm_pkg::sat32(36'(vy_r) + 36'(signed'(ry_r)));
            wz_r <= djnm_pkg::sat32(36'(vz_r) + 36'(signed'(rz_r)));
            we_e_r <= djnm_pkg::sat32(36'(ei_r) + 36'(signed'(re_r)));
            state_r <= S_DONE;
          end else begin
            vx_r <= vx_r + 34'(signed'(rx_r));
            vy_r <= vy_r + 34'(signed'(ry_r));
            vz_r <= vz_r + 34'(signed'(rz_r));
            se_r <= djnm_pkg::sat32(36'(ei_r) + 36'(signed'(re_r)));
            n2_r <= '0; comp_r <= 2'd0; state_r <= S_NORM;
          end
        end
        S_NORM: begin
          // Accumulate squared components, then start the root.
          if (comp_r == 2'd3) state_r <= S_SQRT;
          else begin
            n2_r <= n2_r + mp;
            comp_r <= comp_r + 2'd1;
          end
        end
        S_SQRT: if (sq_done) begin
          mag_r  <= sq_root;
          comp_r <= 2'd0;
          if (sq_root == 34'd0) begin
            if (c_r.cmd == djnm_pkg::CMD_MERGE && !pass_r)
              status_r <= djnm_pkg::ST_ZERO_PMAG;
            // A zero-length candidate is skipped.
            if (pass_r) k_r <= k_r + 1'b1;
            state_r <= pass_r ? S_SCAN : S_DONE;
          end else state_r <= S_UNIT;
        end
        S_UNIT: state_r <= S_DIVW;
        S_DIVW: if (dv_done) begin
          if (c_r.cmd == djnm_pkg::CMD_MERGE) begin
            unique case (comp_r)
              2'd0: wx_r <= rs_val;
              2'd1: wy_r <= rs_val;
              default: wz_r <= rs_val;
            endcase
          end else if (pass_r) uk_r[comp_r] <= neg_c ? -dv_quo[31:0] : dv_quo[31:0];
          else ui_r[comp_r] <= neg_c ? -dv_quo[31:0] : dv_quo[31:0];
          if (comp_r == 2'd2) begin
            if (c_r.cmd == djnm_pkg::CMD_MERGE) begin
              we_r <= 1'b1; waddr_r <= ci; we_e_r <= se_r;
              state_r <= S_DONE;
            end else if (pass_r) begin
              s_r <= '0; comp_r <= 2'd0; state_r <= S_DIST;
            end else begin
              k_r <= '0; pass_r <= 1'b1; state_r <= S_SCAN;
            end
          end else begin
            comp_r <= comp_r + 2'd1;
            state_r <= S_UNIT;
          end
        end
        S_SCAN: begin
          if (k_r == (AW+1)'(TABLE_DEPTH)) state_r <= S_DONE;
          else if (kk == ci || !valid_r[kk]) k_r <= k_r + 1'b1;
          else begin
            raddr_r <= kk;
            state_r <= S_RDK;
          end
        end
        S_RDK: state_r <= S_LATK;
        S_LATK: begin
          kx_r <= rx_r; ky_r <= ry_r; kz_r <= rz_r; ek_r <= re_r;
          n2_r <= '0; comp_r <= 2'd0; state_r <= S_NORM;
        end
        S_DIST: begin
          if (comp_r == 2'd3) begin
            m2_r    <= mp[63:0];
            pacc_r  <= '0;
            mstep_r <= 3'd0;
            state_r <= S_DMUL;
          end else begin
            s_r <= s_r + mp[63:0];
            comp_r <= comp_r + 2'd1;
          end
        end
        S_DMUL: begin
          if (mstep_r == 3'd4) begin
            if (!found_r || dnew < bestd_r) begin
              found_r <= 1'b1;
              bestd_r <= dnew;
              best_r  <= kk;
            end
            k_r <= k_r + 1'b1;
            state_r <= S_SCAN;
          end else begin
            pacc_r  <= pacc_r + pp_sh;
            mstep_r <= mstep_r + 3'd1;
          end
        end
        S_DONE: begin
          out_strobe <= 1'b1;
          out_status <= status_r;
          out_found  <= found_r;
          out_neighbour_index <= 6'(best_r);
          out_distance <= bestd_r;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

### rtl/durham_jet_neighbour_merge.sv
// Durham proto-jet table: load, clear, nearest-neighbour find and merge over
// TABLE_DEPTH entries of Q16.16 four-momenta. Raise start for one beat while
// busy is low; the command enters a two-deep queue and busy rises only when
// that queue is full. Each command yields exactly one result beat on
// out_strobe, which the receiver cannot stall, so it must take every beat.
// Merge in the E0 scheme runs one 34-step square root and three 64-step
// divisions. Find computes the length of the queried entry and of each
// valid candidate, and three unit-vector divisions for each of them on the
// single shared divider; a zero-length candidate is skipped. Write
// cfg_recombine_mode only while idle: 1 selects the E scheme, 0 the E0
// scheme.
module durham_jet_neighbour_merge #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_recombine_mode,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [5:0]  in_entry_index,
  input  logic [5:0]  in_other_index,
  input  logic [31:0] in_mom_x,
  input  logic [31:0] in_mom_y,
  input  logic [31:0] in_mom_z,
  input  logic [31:0] in_energy,
  output logic        out_strobe,
  output logic [1:0]  out_status,
  output logic        out_found,
  output logic [5:0]  out_neighbour_index,
  output logic [63:0] out_distance
);
  logic mode_r;
  logic q_valid, q_pop;
  djnm_pkg::djnm_cmd_t q_data;

  // Recombination mode register; reset selects the E scheme.
  always_ff @(posedge clk) begin
    if (!rst_n) mode_r <= 1'b1;
    else if (cfg_we) mode_r <= cfg_recombine_mode;
  end

  djnm_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
    .clk, .rst_n, .start, .in_command, .in_entry_index, .in_other_index,
    .in_mom_x, .in_mom_y, .in_mom_z, .in_energy, .busy,
    .q_valid, .q_data, .q_pop
  );

  djnm_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk, .rst_n, .mode(mode_r), .q_valid, .q_data, .q_pop,
    .out_strobe, .out_status, .out_found, .out_neighbour_index, .out_distance
  );
endmodule
